@@ hdl/lpb_pkg.sv @@
`default_nettype none

package lpb_pkg;

   typedef enum logic [1:0] {
      PATTERN_CONSTANT = 2'd0,
      PATTERN_PULSE    = 2'd1,
      PATTERN_BLINK    = 2'd2,
      PATTERN_FADE     = 2'd3
   } pattern_kind_type;

   localparam int unsigned LPB_BREATH_DEPTH = 256;

   // phase period and its half, in ms
   localparam logic [15:0] LPB_MS_PER_MIN   = 16'd60000;
   localparam logic [14:0] LPB_HALF_MIN     = 15'd30000;
   localparam logic [2:0]  LPB_LEVEL_FLOOR  = 3'd5;

   // floor(2^k / divisor): quotient estimate low by at most one for x < 2^k
   localparam logic [16:0] LPB_RECIP_MIN32  = 17'd71582;   // 2^32 / 60000
   localparam logic [8:0]  LPB_RECIP_MIN24  = 9'd279;      // 2^24 / 60000
   localparam logic [8:0]  LPB_RECIP_HALF23 = 9'd279;      // 2^23 / 30000

   // level floor times the fade and pulse denominators
   localparam logic [22:0] LPB_FADE_BASE    = 23'd150000;
   localparam logic [25:0] LPB_PULSE_BASE   = 26'd327680;

   // Q30 constants for the breath table
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_E       = 64'd2918732888;
   localparam logic [63:0] Q30_E_INV   = 64'd395007542;
   localparam logic [63:0] BREATH_DEN  = Q30_E - Q30_E_INV;

   localparam logic [63:0] COS_DEN [1:10] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
   localparam logic [63:0] EXP_DEN [1:20] =
      '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
        64'd11, 64'd12, 64'd13, 64'd14, 64'd15, 64'd16, 64'd17, 64'd18, 64'd19,
        64'd20};

   // Breath table entry, Q0.16, from the rounded Q30 angle 2*pi*idx/depth
   // (already folded to 0..pi). Elaboration only.
   function automatic logic [15:0] breath_entry(input logic [63:0] angle);
      logic [63:0] ang;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] mag;
      logic [63:0] lvl;
      logic        neg;
      ang = angle;
      neg = 1'b0;
      if (ang > Q30_PI) begin
         ang = Q30_PI;
      end
      if (ang > Q30_HALF_PI) begin
         ang = Q30_PI - ang;
         neg = 1'b1;
      end
      // cos series, truncated products
      x2   = (ang * ang) >> 30;
      term = Q30_ONE;
      acc  = Q30_ONE;
      for (int k = 1; k <= 10; k++) begin
         term = ((term * x2) >> 30) / COS_DEN[k];
         if (k[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc > (64'd1 << 62)) begin
         acc = 64'd0;   // wrapped just below zero near pi/2
      end
      if (acc > Q30_ONE) begin
         acc = Q30_ONE;
      end
      mag = acc;
      // exp series of +/- mag
      term = Q30_ONE;
      acc  = Q30_ONE;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * mag) >> 30) / EXP_DEN[k];
         if (neg && k[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc <= Q30_E_INV) begin
         return 16'd0;
      end
      lvl = ((acc - Q30_E_INV) * 64'd65536 + (BREATH_DEN >> 1)) / BREATH_DEN;
      if (lvl > 64'd65535) begin
         return 16'hFFFF;
      end
      return lvl[15:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/led_pattern_brightness_unit.sv @@
// Every stage is registered; an accepted req word reaches rsp_tvalid through each stage in order.
// Throughput: one word per cycle while rsp_tready is high; each stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles collapse.
// Reset (synchronous, active high) clears the valid bits only; the breath
// table is constant logic and needs no clearing pass.
`default_nettype none

module led_pattern_brightness_unit #(
   parameter int unsigned BREATH_TABLE_DEPTH = lpb_pkg::LPB_BREATH_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [79:0] req_tdata,   // [7:0] peak_value, [15:8] rate_cpm,
                                         // [47:16] now_ms, [79:48] offset_ms
   input  wire logic [1:0]  req_tuser,   // [1:0] pattern_kind
   // response stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata    // [7:0] brightness
);

   import lpb_pkg::*;

   localparam int unsigned NUM_STAGES = 12;
   // table index width and the scaled phase r*DEPTH (< 60000*DEPTH < 2^SCALED_W)
   localparam int unsigned IDX_W      = $clog2(BREATH_TABLE_DEPTH);
   localparam int unsigned SCALED_W   = 16 + IDX_W;
   localparam int unsigned RECIP_W    = SCALED_W - 15;
   localparam int unsigned PROD_W     = SCALED_W + RECIP_W;
   // floor(2^SCALED_W / 60000): index quotient estimate, low by at most one
   localparam logic [RECIP_W-1:0] RECIP_IDX =
      RECIP_W'((64'd1 << SCALED_W) / 64'(LPB_MS_PER_MIN));

   // ------------------------------------------------------------------
   // Breath table: constant, one entry per phase slot
   // ------------------------------------------------------------------
   logic [15:0] breath_rom [BREATH_TABLE_DEPTH];

   for (genvar gi = 0; gi < BREATH_TABLE_DEPTH; gi++) begin : g_rom
      // mirror symmetry about pi: slot and depth-slot share cos
      localparam int unsigned FOLD =
         (gi <= BREATH_TABLE_DEPTH - gi) ? gi : BREATH_TABLE_DEPTH - gi;
      localparam logic [63:0] ANGLE =
         (64'(FOLD) * 64'd2 * Q30_PI + 64'(BREATH_TABLE_DEPTH / 2)) /
         64'(BREATH_TABLE_DEPTH);
      assign breath_rom[gi] = breath_entry(ANGLE);
   end

   // ------------------------------------------------------------------
   // Pipeline control: per-stage valid, ready ripples back from the output
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] stage_en;

   assign stage_en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_tready;
   for (genvar gs = 1; gs < NUM_STAGES; gs++) begin : g_ready
      assign stage_en[gs] = !valid_ff[gs] || stage_en[gs+1];
   end

   assign valid_in   = {valid_ff[NUM_STAGES-1:1], req_tvalid};
   assign req_tready = stage_en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // pattern and peak ride along through stages 1 to 11
   pattern_kind_type kind_ff [1:NUM_STAGES-1];
   logic [7:0]       peak_ff [1:NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         kind_ff[1] <= pattern_kind_type'(req_tuser[1:0]);
         peak_ff[1] <= req_tdata[7:0];
      end
   end

   for (genvar gc = 2; gc < NUM_STAGES; gc++) begin : g_carry
      always_ff @(posedge clock) begin
         if (stage_en[gc]) begin
            kind_ff[gc] <= kind_ff[gc-1];
            peak_ff[gc] <= peak_ff[gc-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: elapsed time d = now - offset (wraps), rate 0 -> 1
   // ------------------------------------------------------------------
   logic [31:0] d1_ff, d1_in;
   logic [7:0]  rate1_ff, rate1_in;

   always_comb begin
      d1_in    = req_tdata[47:16] - req_tdata[79:48];
      rate1_in = (req_tdata[15:8] == 8'd0) ? 8'd1 : req_tdata[15:8];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         d1_ff    <= d1_in;
         rate1_ff <= rate1_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: d * floor(2^32/60000) for the quotient estimate
   // ------------------------------------------------------------------
   logic [48:0] p2_ff, p2_in;
   logic [31:0] d2_ff;
   logic [7:0]  rate2_ff;

   assign p2_in = 49'(d1_ff) * 49'(LPB_RECIP_MIN32);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         p2_ff    <= p2_in;
         d2_ff    <= d1_ff;
         rate2_ff <= rate1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: partial remainder d - q*60000, in 0..119999
   // ------------------------------------------------------------------
   logic [16:0] q3;
   logic [32:0] qm3;
   logic [31:0] diff3;
   logic [16:0] r3_ff, r3_in;
   logic [7:0]  rate3_ff;

   always_comb begin
      q3    = p2_ff[48:32];
      qm3   = 33'(q3) * 33'(LPB_MS_PER_MIN);
      diff3 = d2_ff - qm3[31:0];
      r3_in = diff3[16:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         r3_ff    <= r3_in;
         rate3_ff <= rate2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: finish d mod 60000, then times rate (< 60000*255)
   // ------------------------------------------------------------------
   logic [15:0] dmod4;
   logic [23:0] x4_ff, x4_in;

   always_comb begin
      if (r3_ff >= 17'(LPB_MS_PER_MIN)) begin
         dmod4 = 16'(r3_ff - 17'(LPB_MS_PER_MIN));
      end else begin
         dmod4 = r3_ff[15:0];
      end
      x4_in = 24'(dmod4) * 24'(rate3_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         x4_ff <= x4_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: x * floor(2^24/60000)
   // ------------------------------------------------------------------
   logic [32:0] p5_ff, p5_in;
   logic [23:0] x5_ff;

   assign p5_in = 33'(x4_ff) * 33'(LPB_RECIP_MIN24);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         p5_ff <= p5_in;
         x5_ff <= x4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: partial phase remainder, 0..119999
   // ------------------------------------------------------------------
   logic [8:0]  q6;
   logic [24:0] qm6;
   logic [23:0] diff6;
   logic [16:0] r6_ff, r6_in;

   always_comb begin
      q6    = p5_ff[32:24];
      qm6   = 25'(q6) * 25'(LPB_MS_PER_MIN);
      diff6 = x5_ff - qm6[23:0];
      r6_in = diff6[16:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         r6_ff <= r6_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: phase r = (d*rate) mod 60000, and r*DEPTH for the index
   // ------------------------------------------------------------------
   logic [15:0]         r7_ff, r7_in;
   logic [SCALED_W-1:0] y7_ff, y7_in;

   always_comb begin
      if (r6_ff >= 17'(LPB_MS_PER_MIN)) begin
         r7_in = 16'(r6_ff - 17'(LPB_MS_PER_MIN));
      end else begin
         r7_in = r6_ff[15:0];
      end
      y7_in = SCALED_W'(r7_in) * SCALED_W'(BREATH_TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         r7_ff <= r7_in;
         y7_ff <= y7_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: first-half flag, triangle t, index quotient product
   // ------------------------------------------------------------------
   logic                half8_ff, half8_in;
   logic [14:0]         t8_ff, t8_in;
   logic [PROD_W-1:0]   p8_ff, p8_in;
   logic [SCALED_W-1:0] y8_ff;

   always_comb begin
      half8_in = (r7_ff < 16'(LPB_HALF_MIN));
      if (half8_in) begin
         t8_in = r7_ff[14:0];
      end else begin
         t8_in = 15'(LPB_MS_PER_MIN - r7_ff);
      end
      p8_in = PROD_W'(y7_ff) * PROD_W'(RECIP_IDX);
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         half8_ff <= half8_in;
         t8_ff    <= t8_in;
         p8_ff    <= p8_in;
         y8_ff    <= y7_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 9: fade numerator; index estimate and its remainder
   // ------------------------------------------------------------------
   logic                half9_ff;
   logic [22:0]         nf9_ff, nf9_in;
   logic [IDX_W-1:0]    q9_ff, q9_in;
   logic [SCALED_W-1:0] qm9;
   logic [SCALED_W-1:0] diff9;
   logic [16:0]         rem9_ff, rem9_in;

   always_comb begin
      // 5*30000 + t*(peak - 5), never negative since t <= 30000
      nf9_in  = LPB_FADE_BASE - 23'(t8_ff) * 23'(LPB_LEVEL_FLOOR)
                + 23'(t8_ff) * 23'(peak_ff[8]);
      q9_in   = p8_ff[SCALED_W +: IDX_W];
      qm9     = SCALED_W'(q9_in) * SCALED_W'(LPB_MS_PER_MIN);
      diff9   = y8_ff - qm9;
      rem9_in = diff9[16:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         half9_ff <= half8_ff;
         nf9_ff   <= nf9_in;
         q9_ff    <= q9_in;
         rem9_ff  <= rem9_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 10: table index; fade quotient product
   // ------------------------------------------------------------------
   logic             half10_ff;
   logic [22:0]      nf10_ff;
   logic [31:0]      pf10_ff, pf10_in;
   logic [IDX_W-1:0] idx10_ff, idx10_in;

   always_comb begin
      idx10_in = q9_ff + IDX_W'(rem9_ff >= 17'(LPB_MS_PER_MIN));
      pf10_in  = 32'(nf9_ff) * 32'(LPB_RECIP_HALF23);
   end

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         half10_ff <= half9_ff;
         nf10_ff   <= nf9_ff;
         pf10_ff   <= pf10_in;
         idx10_ff  <= idx10_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 11: breath table read; fade quotient estimate and remainder
   // ------------------------------------------------------------------
   logic        half11_ff;
   logic [15:0] e11_ff, e11_in;
   logic [8:0]  q11_ff, q11_in;
   logic [23:0] qm11;
   logic [23:0] diff11;
   logic [15:0] rem11_ff, rem11_in;

   always_comb begin
      e11_in   = breath_rom[idx10_ff];
      q11_in   = pf10_ff[31:23];
      qm11     = 24'(q11_in) * 24'(LPB_HALF_MIN);
      diff11   = 24'(nf10_ff) - qm11;
      rem11_in = diff11[15:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         half11_ff <= half10_ff;
         e11_ff    <= e11_in;
         q11_ff    <= q11_in;
         rem11_ff  <= rem11_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 12: pulse scale, fade correction, pattern select, clamp
   // ------------------------------------------------------------------
   logic [8:0]  fade_q;
   logic [7:0]  fade_val;
   logic [25:0] pulse_sum;
   logic [7:0]  pulse_val;
   logic [7:0]  rsp_ff, rsp_in;

   always_comb begin
      fade_q    = q11_ff + 9'(rem11_ff >= 16'(LPB_HALF_MIN));
      fade_val  = (fade_q > 9'd255) ? 8'hFF : fade_q[7:0];
      // 5*65536 + e*(peak - 5); 5*e stays below 5*65536
      pulse_sum = LPB_PULSE_BASE - 26'(e11_ff) * 26'(LPB_LEVEL_FLOOR)
                  + 26'(e11_ff) * 26'(peak_ff[11]);
      pulse_val = (pulse_sum[25:16] > 10'd255) ? 8'hFF : pulse_sum[23:16];

      if (peak_ff[11] == 8'd0) begin
         rsp_in = 8'd0;
      end else begin
         case (kind_ff[11])
            PATTERN_CONSTANT: begin
               rsp_in = peak_ff[11];
            end
            PATTERN_BLINK: begin
               rsp_in = half11_ff ? peak_ff[11] : 8'd0;
            end
            PATTERN_FADE: begin
               rsp_in = fade_val;
            end
            default: begin
               rsp_in = pulse_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES];
   assign rsp_tdata  = rsp_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // first reduction leaves at most one extra period
   a_first_reduce: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> r3_ff < 17'(2 * LPB_MS_PER_MIN))
      else $error("d mod 60000 estimate out of range");

   // phase fully reduced
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[7] |-> r7_ff < LPB_MS_PER_MIN)
      else $error("phase not below 60000");

   // table index stays inside the table
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[10] |-> 32'(idx10_ff) < BREATH_TABLE_DEPTH)
      else $error("breath index past table end");

   // fade quotient estimate off by at most one
   a_fade_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[11] |-> rem11_ff < 16'(2 * LPB_HALF_MIN))
      else $error("fade remainder out of range");

   // a blocked output holds the word behind it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[12] && !rsp_tready && valid_ff[11] |=> valid_ff[11] && valid_ff[12])
      else $error("word lost behind stalled output");

endmodule

`default_nettype wire
